// ===== rtl/core/tip_pkg.sv =====
// tip_pkg: shared constants, codes and reply tables of the telnet IAC parser.
// No dependencies; used by tip_ctrl, telnet_iac_parser, the checker and the bench.
package tip_pkg;

	// telnet command bytes
	localparam logic [7:0] T_IAC  = 8'd255;
	localparam logic [7:0] T_DONT = 8'd254;
	localparam logic [7:0] T_DO   = 8'd253;
	localparam logic [7:0] T_WILL = 8'd251;
	localparam logic [7:0] T_SB   = 8'd250;
	localparam logic [7:0] T_BRK  = 8'd243;
	localparam logic [7:0] T_SE   = 8'd240;

	// option codes
	localparam logic [7:0] O_ECHO     = 8'd1;
	localparam logic [7:0] O_SGA      = 8'd3;
	localparam logic [7:0] O_TTYPE    = 8'd24;
	localparam logic [7:0] O_NAWS     = 8'd31;
	localparam logic [7:0] O_LINEMODE = 8'd34;
	localparam logic [7:0] SB_SEND    = 8'd1;

	// result kinds
	localparam logic [2:0] KIND_USER  = 3'd0;
	localparam logic [2:0] KIND_REPLY = 3'd1;
	localparam logic [2:0] KIND_WIN   = 3'd2;
	localparam logic [2:0] KIND_TTYPE = 3'd3;
	localparam logic [2:0] KIND_LBRK  = 3'd4;
	localparam logic [2:0] KIND_RBRK  = 3'd5;

	// break_mode register codes
	localparam logic [1:0] BRK_NONE   = 2'd0;
	localparam logic [1:0] BRK_LOCAL  = 2'd1;
	localparam logic [1:0] BRK_REMOTE = 2'd2;

	// command position codes
	localparam logic [1:0] CMD_DATA = 2'd0;
	localparam logic [1:0] CMD_VERB = 2'd1;
	localparam logic [1:0] CMD_OPT  = 2'd2;

	// NAWS payload: option byte then four size bytes at store index 1..4
	localparam logic [2:0] NAWS_END = 3'd4;

	typedef enum logic [1:0] {
		REP_LINEMODE = 2'd0,
		REP_TTYPE    = 2'd1,
		REP_NAWS     = 2'd2,
		REP_SGA      = 2'd3
	} rep_sel_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  value;
		logic [15:0] columns;
		logic [15:0] rows;
		logic        last;
	} tip_res_t;

	function automatic logic [3:0] rep_len(input rep_sel_t sel);
		logic [3:0] n;
		case (sel)
			REP_LINEMODE: n = 4'd9;
			REP_TTYPE:    n = 4'd9;
			REP_NAWS:     n = 4'd3;
			REP_SGA:      n = 4'd6;
			default:      n = 4'd1;
		endcase
		return n;
	endfunction

	function automatic logic [7:0] rep_byte(input rep_sel_t sel, input logic [3:0] idx);
		logic [7:0] v;
		v = 8'd0;
		case (sel)
			REP_LINEMODE: begin
				case (idx)
					4'd0: v = T_IAC;
					4'd1: v = T_DONT;
					4'd2: v = O_LINEMODE;
					4'd3: v = T_IAC;
					4'd4: v = T_DONT;
					4'd5: v = O_ECHO;
					4'd6: v = T_IAC;
					4'd7: v = T_WILL;
					4'd8: v = O_ECHO;
					default: v = 8'd0;
				endcase
			end
			REP_TTYPE: begin
				case (idx)
					4'd0: v = T_IAC;
					4'd1: v = T_DO;
					4'd2: v = O_TTYPE;
					4'd3: v = T_IAC;
					4'd4: v = T_SB;
					4'd5: v = O_TTYPE;
					4'd6: v = SB_SEND;
					4'd7: v = T_IAC;
					4'd8: v = T_SE;
					default: v = 8'd0;
				endcase
			end
			REP_NAWS: begin
				case (idx)
					4'd0: v = T_IAC;
					4'd1: v = T_DO;
					4'd2: v = O_NAWS;
					default: v = 8'd0;
				endcase
			end
			REP_SGA: begin
				case (idx)
					4'd0: v = T_IAC;
					4'd1: v = T_WILL;
					4'd2: v = O_SGA;
					4'd3: v = T_IAC;
					4'd4: v = T_DO;
					4'd5: v = O_SGA;
					default: v = 8'd0;
				endcase
			end
			default: v = 8'd0;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/core/tip_ifs.sv =====
// tip_ifs: valid/ready channel interfaces for received bytes and parser results.
// No dependencies.
interface tip_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface tip_res_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [7:0]  value;
	logic [15:0] columns;
	logic [15:0] rows;
	logic        last;

	modport source (output valid, output kind, output value, output columns, output rows,
		output last, input ready);
	modport sink (input valid, input kind, input value, input columns, input rows,
		input last, output ready);
endinterface

// ===== rtl/core/tip_sub_mem.sv =====
// tip_sub_mem: subnegotiation byte store, one write and one registered read port.
// No dependencies; contents are undefined until written.
module tip_sub_mem #(
	parameter int DEPTH = 40,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/core/tip_ctrl.sv =====
// tip_ctrl: byte parser, subnegotiation sequencer and result output register.
// Depends on tip_pkg, tip_ifs; drives the tip_sub_mem ports.
module tip_ctrl #(
	parameter int SUB_DEPTH = 40,
	parameter int TTYPE_MAX = 16,
	localparam int AW = $clog2(SUB_DEPTH),
	localparam int CW = $clog2(SUB_DEPTH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [1:0]    break_mode,
	tip_byte_if.sink      rx,
	tip_res_if.source     evt,
	output logic          mem_we,
	output logic [AW-1:0] mem_waddr,
	output logic [7:0]    mem_wdata,
	output logic [AW-1:0] mem_raddr,
	input  logic [7:0]    mem_rdata
);
	import tip_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_RUN  = 6'b000010,
		ST_HEAD = 6'b000100,
		ST_OPT  = 6'b001000,
		ST_NAWS = 6'b010000,
		ST_TT   = 6'b100000
	} state_t;

	state_t      state_q;
	logic        in_sub_q, saw_iac_q;
	logic [1:0]  pos_q;
	logic [7:0]  verb_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] ptr_q;
	logic [31:0] naws_q;
	logic        job_rep_q;
	rep_sel_t    rep_sel_q;
	logic [3:0]  rep_idx_q;
	logic [2:0]  job_kind_q;
	logic [7:0]  job_val_q;
	logic        out_vld_q;
	tip_res_t    out_q;

	// parse decode
	logic        acc;
	logic [7:0]  b;
	logic        in_sub_d, saw_iac_d;
	logic [1:0]  pos_d;
	logic [7:0]  verb_d;
	logic [CW-1:0] cnt_d;
	logic        put, end_sub, one, rep;
	logic [2:0]  one_kind;
	logic [7:0]  one_val;
	rep_sel_t    rep_sel_d;

	// sequencer
	logic        free, load, tt_last, opt_tt;
	tip_res_t    nres;
	logic [CW-1:0] raddr_w;
	logic [7:0]  naws_byte;

	assign acc  = rx.valid && rx.ready;
	assign b    = rx.rx_byte;
	assign free = !out_vld_q || evt.ready;

	always_comb begin
		in_sub_d  = in_sub_q;
		saw_iac_d = saw_iac_q;
		pos_d     = pos_q;
		verb_d    = verb_q;
		cnt_d     = cnt_q;
		put       = 1'b0;
		end_sub   = 1'b0;
		one       = 1'b0;
		one_kind  = KIND_USER;
		one_val   = b;
		rep       = 1'b0;
		rep_sel_d = REP_NAWS;
		if (in_sub_q) begin
			if (saw_iac_q) begin
				saw_iac_d = 1'b0;
				if (b == T_SE) begin
					end_sub  = 1'b1;
					in_sub_d = 1'b0;
					pos_d    = CMD_DATA;
				end else begin
					put = 1'b1;
				end
			end else if (b == T_IAC) begin
				saw_iac_d = 1'b1;
			end else begin
				put = 1'b1;
			end
		end else begin
			case (pos_q)
				CMD_VERB: begin
					if (b == T_IAC) begin
						one   = 1'b1;
						pos_d = CMD_DATA;
					end else if (b == T_SB) begin
						in_sub_d  = 1'b1;
						saw_iac_d = 1'b0;
						cnt_d     = '0;
					end else if (b == T_BRK) begin
						pos_d   = CMD_DATA;
						one_val = 8'd0;
						if (break_mode == BRK_LOCAL) begin
							one      = 1'b1;
							one_kind = KIND_LBRK;
						end else if (break_mode == BRK_REMOTE) begin
							one      = 1'b1;
							one_kind = KIND_RBRK;
						end
					end else begin
						verb_d = b;
						pos_d  = CMD_OPT;
					end
				end
				CMD_OPT: begin
					pos_d = CMD_DATA;
					if (verb_q == T_WILL) begin
						if (b == O_LINEMODE) begin
							rep       = 1'b1;
							rep_sel_d = REP_LINEMODE;
						end else if (b == O_TTYPE) begin
							rep       = 1'b1;
							rep_sel_d = REP_TTYPE;
						end else if (b == O_NAWS) begin
							rep       = 1'b1;
							rep_sel_d = REP_NAWS;
						end
					end else if (verb_q == T_DO && b == O_SGA) begin
						rep       = 1'b1;
						rep_sel_d = REP_SGA;
					end
				end
				default: begin
					if (b == T_IAC) begin
						pos_d = CMD_VERB;
					end else begin
						pos_d = CMD_DATA;
						one   = 1'b1;
					end
				end
			endcase
		end
		// store full: abort the subnegotiation
		if (put) begin
			cnt_d = cnt_q + CW'(1);
			if (cnt_d == CW'(SUB_DEPTH)) begin
				in_sub_d  = 1'b0;
				saw_iac_d = 1'b0;
				pos_d     = CMD_DATA;
			end
		end
	end

	assign mem_we    = acc && put;
	assign mem_waddr = cnt_q[AW-1:0];
	assign mem_wdata = b;

	assign opt_tt    = (mem_rdata == O_TTYPE);
	assign naws_byte = (ptr_q < cnt_q) ? mem_rdata : 8'h00;
	assign tt_last   = (int'(ptr_q) + 1 == int'(cnt_q)) || (int'(ptr_q) == TTYPE_MAX + 1);

	always_comb begin
		load    = 1'b0;
		nres    = '0;
		raddr_w = ptr_q;
		case (state_q)
			ST_RUN: begin
				if (free) begin
					load = 1'b1;
					if (job_rep_q) begin
						nres.kind  = KIND_REPLY;
						nres.value = rep_byte(rep_sel_q, rep_idx_q);
						nres.last  = (rep_idx_q == rep_len(rep_sel_q) - 4'd1);
					end else begin
						nres.kind  = job_kind_q;
						nres.value = job_val_q;
						nres.last  = 1'b1;
						if (job_kind_q == KIND_WIN) begin
							nres.columns = naws_q[31:16];
							nres.rows    = naws_q[15:0];
						end
					end
				end
			end
			ST_HEAD: raddr_w = '0;
			ST_OPT:  raddr_w = opt_tt ? CW'(2) : CW'(1);
			ST_NAWS: raddr_w = ptr_q + CW'(1);
			ST_TT: begin
				// hold the read address while stalled so the data stays put
				if (free) begin
					load       = 1'b1;
					nres.kind  = KIND_TTYPE;
					nres.value = mem_rdata;
					nres.last  = tt_last;
					raddr_w    = ptr_q + CW'(1);
				end
			end
			default: raddr_w = ptr_q;
		endcase
	end

	assign mem_raddr = raddr_w[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			in_sub_q   <= 1'b0;
			saw_iac_q  <= 1'b0;
			pos_q      <= CMD_DATA;
			verb_q     <= 8'd0;
			cnt_q      <= '0;
			ptr_q      <= '0;
			naws_q     <= '0;
			job_rep_q  <= 1'b0;
			rep_sel_q  <= REP_NAWS;
			rep_idx_q  <= '0;
			job_kind_q <= KIND_USER;
			job_val_q  <= 8'd0;
			out_vld_q  <= 1'b0;
		end else begin
			if (load) begin
				out_vld_q <= 1'b1;
			end else if (evt.ready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						in_sub_q  <= in_sub_d;
						saw_iac_q <= saw_iac_d;
						pos_q     <= pos_d;
						verb_q    <= verb_d;
						cnt_q     <= cnt_d;
						if (one) begin
							job_rep_q  <= 1'b0;
							job_kind_q <= one_kind;
							job_val_q  <= one_val;
							state_q    <= ST_RUN;
						end else if (rep) begin
							job_rep_q <= 1'b1;
							rep_sel_q <= rep_sel_d;
							rep_idx_q <= '0;
							state_q   <= ST_RUN;
						end else if (end_sub && cnt_q != '0) begin
							state_q <= ST_HEAD;
						end
					end
				end
				ST_RUN: begin
					if (load) begin
						rep_idx_q <= rep_idx_q + 4'd1;
						if (nres.last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_HEAD: state_q <= ST_OPT;
				ST_OPT: begin
					ptr_q <= raddr_w;
					if (mem_rdata == O_NAWS) begin
						state_q <= ST_NAWS;
					end else if (opt_tt && cnt_q > CW'(2)) begin
						state_q <= ST_TT;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_NAWS: begin
					naws_q <= {naws_q[23:0], naws_byte};
					ptr_q  <= raddr_w;
					if (ptr_q == CW'(NAWS_END)) begin
						job_rep_q  <= 1'b0;
						job_kind_q <= KIND_WIN;
						job_val_q  <= 8'd0;
						state_q    <= ST_RUN;
					end
				end
				ST_TT: begin
					if (load) begin
						ptr_q <= raddr_w;
						if (tt_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= nres;
		end
	end

	assign rx.ready    = (state_q == ST_IDLE);
	assign evt.valid   = out_vld_q;
	assign evt.kind    = out_q.kind;
	assign evt.value   = out_q.value;
	assign evt.columns = out_q.columns;
	assign evt.rows    = out_q.rows;
	assign evt.last    = out_q.last;

endmodule

// ===== rtl/core/telnet_iac_parser.sv =====
// telnet_iac_parser: telnet receive parser, top level. Depends on tip_pkg, tip_ifs,
// tip_sub_mem and tip_ctrl.
// Bytes are taken only in the idle state; a data or store byte that yields no result keeps
// it idle, while a byte that yields results holds input off until they are all loaded; a reply
// run is 3 to 9 bytes. IAC SE reads the byte store at one read per cycle while not stalled.
// Reset: parser state clears and break_mode returns to local; the store is not cleared.
module telnet_iac_parser #(
	parameter int SUB_DEPTH = 40,
	parameter int TTYPE_MAX = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	tip_byte_if.sink  rx,
	tip_res_if.source evt,
	input  logic      cfg_we,
	input  logic [1:0] cfg_wdata
);
	import tip_pkg::*;

	localparam int AW = $clog2(SUB_DEPTH);

	logic [1:0]    break_mode_q;
	logic          mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [7:0]    mem_wdata, mem_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			break_mode_q <= BRK_LOCAL;
		end else if (cfg_we) begin
			break_mode_q <= cfg_wdata;
		end
	end

	tip_sub_mem #(
		.DEPTH(SUB_DEPTH)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	tip_ctrl #(
		.SUB_DEPTH(SUB_DEPTH),
		.TTYPE_MAX(TTYPE_MAX)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.break_mode(break_mode_q),
		.rx        (rx),
		.evt       (evt),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

endmodule

// ===== rtl/core/tip_chk.sv =====
// tip_chk: port-level checker for telnet_iac_parser, attached by bind.
// Depends on tip_pkg.
module tip_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        rx_ready,
	input logic        evt_valid,
	input logic        evt_ready,
	input logic [2:0]  kind,
	input logic [7:0]  value,
	input logic [15:0] columns,
	input logic [15:0] rows,
	input logic        last
);
	import tip_pkg::*;

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && !evt_ready |=> evt_valid)
		else $error("result beat dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && !evt_ready |=> $stable(kind) && $stable(value) && $stable(last))
		else $error("result beat changed while stalled");

	a_size_only_win: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && kind != KIND_WIN |-> columns == 16'd0 && rows == 16'd0)
		else $error("window size on a non-size result");

	a_no_value_evt: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && (kind == KIND_WIN || kind == KIND_LBRK || kind == KIND_RBRK)
			|-> value == 8'd0 && last)
		else $error("event result with value or not last");

	a_run_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && !last |-> !rx_ready)
		else $error("input taken while a result run is open");

endmodule

bind telnet_iac_parser tip_chk u_tip_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.rx_ready (rx.ready),
	.evt_valid(evt.valid),
	.evt_ready(evt.ready),
	.kind     (evt.kind),
	.value    (evt.value),
	.columns  (evt.columns),
	.rows     (evt.rows),
	.last     (evt.last)
);

// ===== tb/sv/tb_telnet_iac_parser.sv =====
`timescale 1ns / 1ps
// tb_telnet_iac_parser: self-checking bench for the telnet receive parser; a scoreboard class
// predicts events per received byte. Depends on tip_pkg, tip_ifs and telnet_iac_parser.
module tb_telnet_iac_parser;
	import tip_pkg::*;

	localparam int SUB_DEPTH = 40;
	localparam int TTYPE_MAX = 16;
	localparam int SETTLE_CYCLES = 32;
	localparam logic [7:0] VERB_WONT = 8'd252;
	localparam logic [7:0] TT_IS = 8'd0;

	class telnet_event_board;
		logic [1:0] brk_mode;
		bit in_sub;
		bit saw_iac;
		logic [1:0] cmd_pos;
		logic [7:0] cmd_verb;
		logic [7:0] store [SUB_DEPTH];
		int sub_count;
		tip_res_t pending_events[$];
		tip_res_t step_events[$];
		int mismatches;
		int matched;
		int windows;
		int ttype_chars;
		int breaks;
		int aborts;
		logic [7:0] linemode_run [9] = '{T_IAC, T_DONT, O_LINEMODE, T_IAC, T_DONT, O_ECHO,
			T_IAC, T_WILL, O_ECHO};
		logic [7:0] ttype_run [9] = '{T_IAC, T_DO, O_TTYPE, T_IAC, T_SB, O_TTYPE, SB_SEND,
			T_IAC, T_SE};
		logic [7:0] naws_run [3] = '{T_IAC, T_DO, O_NAWS};
		logic [7:0] sga_run [6] = '{T_IAC, T_WILL, O_SGA, T_IAC, T_DO, O_SGA};

		function new();
			brk_mode = BRK_LOCAL;
			in_sub = 1'b0;
			saw_iac = 1'b0;
			cmd_pos = CMD_DATA;
			cmd_verb = 8'd0;
			foreach (store[i]) store[i] = 8'd0;
			sub_count = 0;
			mismatches = 0;
			matched = 0;
			windows = 0;
			ttype_chars = 0;
			breaks = 0;
			aborts = 0;
		endfunction

		function int outstanding();
			return pending_events.size();
		endfunction

		function void add(logic [2:0] k, logic [7:0] v, logic [15:0] c, logic [15:0] r);
			tip_res_t e;
			e.kind = k;
			e.value = v;
			e.columns = c;
			e.rows = r;
			e.last = 1'b0;
			step_events.push_back(e);
		endfunction

		function logic [7:0] stored(int i);
			return (i < sub_count && i < SUB_DEPTH) ? store[i] : 8'h00;
		endfunction

		function void put(logic [7:0] b);
			if (sub_count < SUB_DEPTH)
				store[sub_count] = b;
			sub_count++;
			// store full: drop the subnegotiation, back to plain data
			if (sub_count >= SUB_DEPTH) begin
				in_sub = 1'b0;
				saw_iac = 1'b0;
				cmd_pos = CMD_DATA;
				aborts++;
			end
		endfunction

		function void close_sub();
			int i;
			in_sub = 1'b0;
			saw_iac = 1'b0;
			cmd_pos = CMD_DATA;
			if (sub_count == 0)
				return;
			if (store[0] == O_NAWS) begin
				add(KIND_WIN, 8'd0, {stored(1), stored(2)}, {stored(3), stored(4)});
				windows++;
			end else if (store[0] == O_TTYPE) begin
				for (i = 2; i < sub_count && i < SUB_DEPTH && i - 2 < TTYPE_MAX; i++) begin
					add(KIND_TTYPE, store[i], 16'd0, 16'd0);
					ttype_chars++;
				end
			end
		endfunction

		// work out the events one accepted byte causes and queue them
		function void take_byte(logic [7:0] b);
			tip_res_t tail;
			step_events.delete();
			if (in_sub) begin
				if (saw_iac) begin
					saw_iac = 1'b0;
					if (b == T_SE)
						close_sub();
					else
						put(b);
				end else if (b == T_IAC) begin
					saw_iac = 1'b1;
				end else begin
					put(b);
				end
			end else if (cmd_pos == CMD_VERB) begin
				if (b == T_IAC) begin
					add(KIND_USER, b, 16'd0, 16'd0);
					cmd_pos = CMD_DATA;
				end else if (b == T_SB) begin
					in_sub = 1'b1;
					saw_iac = 1'b0;
					sub_count = 0;
				end else if (b == T_BRK) begin
					cmd_pos = CMD_DATA;
					breaks++;
					if (brk_mode == BRK_LOCAL)
						add(KIND_LBRK, 8'd0, 16'd0, 16'd0);
					else if (brk_mode == BRK_REMOTE)
						add(KIND_RBRK, 8'd0, 16'd0, 16'd0);
				end else begin
					cmd_verb = b;
					cmd_pos = CMD_OPT;
				end
			end else if (cmd_pos == CMD_OPT) begin
				cmd_pos = CMD_DATA;
				if (cmd_verb == T_WILL) begin
					if (b == O_LINEMODE)
						foreach (linemode_run[i]) add(KIND_REPLY, linemode_run[i], 16'd0, 16'd0);
					else if (b == O_TTYPE)
						foreach (ttype_run[i]) add(KIND_REPLY, ttype_run[i], 16'd0, 16'd0);
					else if (b == O_NAWS)
						foreach (naws_run[i]) add(KIND_REPLY, naws_run[i], 16'd0, 16'd0);
				end else if (cmd_verb == T_DO && b == O_SGA) begin
					foreach (sga_run[i]) add(KIND_REPLY, sga_run[i], 16'd0, 16'd0);
				end
			end else begin
				cmd_pos = CMD_DATA;
				if (b == T_IAC)
					cmd_pos = CMD_VERB;
				else
					add(KIND_USER, b, 16'd0, 16'd0);
			end
			if (step_events.size() > 0) begin
				tail = step_events.pop_back();
				tail.last = 1'b1;
				step_events.push_back(tail);
			end
			foreach (step_events[i]) pending_events.push_back(step_events[i]);
		endfunction

		function void flag(string what, tip_res_t want, tip_res_t got);
			mismatches++;
			if (mismatches <= 10) begin
				$display("%0t %s: expected kind=%0d value=%02h cols=%0d rows=%0d last=%0d",
					$time, what, want.kind, want.value, want.columns, want.rows, want.last);
				$display("    got kind=%0d value=%02h cols=%0d rows=%0d last=%0d",
					got.kind, got.value, got.columns, got.rows, got.last);
			end
		endfunction

		function void match_event(tip_res_t got);
			tip_res_t want;
			if (pending_events.size() == 0) begin
				flag("unexpected event", '0, got);
				return;
			end
			want = pending_events.pop_front();
			if (got.kind !== want.kind || got.value !== want.value ||
					got.columns !== want.columns || got.rows !== want.rows ||
					got.last !== want.last)
				flag("event mismatch", want, got);
			else
				matched++;
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_wdata;
	bit calm;
	int bytes_sent;
	telnet_event_board board;

	tip_byte_if rx_if();
	tip_res_if evt_if();

	telnet_iac_parser #(
		.SUB_DEPTH(SUB_DEPTH),
		.TTYPE_MAX(TTYPE_MAX)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx_if),
		.evt(evt_if),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("telnet_iac_parser test failed");
		$finish;
	end

	// event sink with random stall bursts
	initial begin
		evt_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!calm && $urandom_range(0, 3) == 0) begin
				evt_if.ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end
			evt_if.ready <= 1'b1;
			repeat ($urandom_range(1, 24)) @(posedge clk);
		end
	end

	always @(posedge clk) begin : watch
		tip_res_t seen;
		seen = {evt_if.kind, evt_if.value, evt_if.columns, evt_if.rows, evt_if.last};
		if (arst_n && evt_if.valid && evt_if.ready)
			board.match_event(seen);
	end

	task automatic send_byte(input logic [7:0] b);
		if (!calm && $urandom_range(0, 4) == 0) begin
			rx_if.valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		rx_if.valid <= 1'b1;
		rx_if.rx_byte <= b;
		@(posedge clk);
		while (!rx_if.ready) @(posedge clk);
		board.take_byte(b);
		bytes_sent++;
	endtask

	task automatic send_cmd(input logic [7:0] verb, input logic [7:0] opt);
		send_byte(T_IAC);
		send_byte(verb);
		send_byte(opt);
	endtask

	task automatic open_sub();
		send_byte(T_IAC);
		send_byte(T_SB);
	endtask

	task automatic shut_sub();
		send_byte(T_IAC);
		send_byte(T_SE);
	endtask

	// a data beat inside a subnegotiation, 255 escaped as IAC IAC
	task automatic send_sub_data(input logic [7:0] b);
		if (b == T_IAC)
			send_byte(T_IAC);
		send_byte(b);
	endtask

	function automatic logic [7:0] rand_payload();
		return ($urandom_range(0, 7) == 0) ? T_IAC : 8'($urandom_range(0, 255));
	endfunction

	task automatic send_overflow();
		int n;
		n = $urandom_range(SUB_DEPTH, SUB_DEPTH + 3);
		open_sub();
		repeat (n) send_sub_data(8'($urandom_range(0, 254)));
		if ($urandom_range(0, 1) == 0)
			shut_sub();
	endtask

	task automatic send_message();
		logic [7:0] verb;
		logic [7:0] opt;
		int n;
		case ($urandom_range(0, 19))
			0, 1, 2, 3, 18: send_byte(8'($urandom_range(0, 254)));
			4: begin
				send_byte(T_IAC);
				send_byte(T_IAC);
			end
			5, 6, 7, 8: begin
				case ($urandom_range(0, 5))
					0, 1: verb = T_WILL;
					2: verb = T_DO;
					3: verb = T_DONT;
					4: verb = VERB_WONT;
					default: verb = 8'($urandom_range(0, 255));
				endcase
				case ($urandom_range(0, 5))
					0: opt = O_LINEMODE;
					1: opt = O_TTYPE;
					2: opt = O_NAWS;
					3: opt = O_SGA;
					4: opt = O_ECHO;
					default: opt = 8'($urandom_range(0, 255));
				endcase
				send_cmd(verb, opt);
			end
			9: begin
				send_byte(T_IAC);
				send_byte(T_BRK);
			end
			10, 11, 12: begin
				n = ($urandom_range(0, 2) != 0) ? 4 : $urandom_range(0, 6);
				open_sub();
				send_byte(O_NAWS);
				repeat (n) send_sub_data(rand_payload());
				shut_sub();
			end
			13, 14, 15: begin
				n = ($urandom_range(0, 3) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 8);
				open_sub();
				send_byte(O_TTYPE);
				send_sub_data(TT_IS);
				repeat (n) send_sub_data(rand_payload());
				shut_sub();
			end
			16: begin
				// odd subnegotiation: empty, lone SE, IAC before plain data
				open_sub();
				if ($urandom_range(0, 2) != 0) begin
					case ($urandom_range(0, 2))
						0: send_byte(O_NAWS);
						1: send_byte(O_TTYPE);
						default: send_sub_data(rand_payload());
					endcase
					repeat ($urandom_range(0, 4)) begin
						case ($urandom_range(0, 2))
							0: send_byte(T_SE);
							1: begin
								send_byte(T_IAC);
								send_byte(8'($urandom_range(0, 239)));
							end
							default: send_sub_data(rand_payload());
						endcase
					end
				end
				shut_sub();
			end
			17: repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
			default: begin
				if ($urandom_range(0, 3) == 0)
					send_overflow();
				else
					send_byte(8'($urandom_range(0, 255)));
			end
		endcase
	endtask

	task automatic random_run(input int quota);
		int stop;
		stop = bytes_sent + quota;
		while (bytes_sent < stop) send_message();
	endtask

	task automatic await_quiet();
		rx_if.valid <= 1'b0;
		while (board.outstanding() > 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_break_mode(input logic [1:0] m);
		cfg_wdata <= m;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.brk_mode = m;
	endtask

	task automatic directed_run();
		send_byte(8'h00);
		send_byte(T_IAC);
		send_byte(T_IAC);
		send_cmd(T_WILL, O_LINEMODE);
		send_cmd(T_WILL, O_TTYPE);
		send_cmd(T_WILL, O_NAWS);
		send_cmd(T_DO, O_SGA);
		send_byte(T_IAC);
		send_byte(T_BRK);
		// widest window: 0xffff columns, zero rows
		open_sub();
		send_byte(O_NAWS);
		send_sub_data(T_IAC);
		send_sub_data(T_IAC);
		send_sub_data(8'h00);
		send_sub_data(8'h00);
		shut_sub();
	endtask

	// corner cases, run with break events off
	task automatic edge_run();
		send_byte(T_IAC);
		send_byte(T_BRK);
		open_sub();
		shut_sub();
		open_sub();
		send_byte(O_NAWS);
		send_byte(8'h01);
		shut_sub();
		open_sub();
		send_byte(O_TTYPE);
		send_byte(TT_IS);
		shut_sub();
		open_sub();
		send_byte(O_TTYPE);
		send_byte(TT_IS);
		send_byte(T_SE);
		send_byte(T_IAC);
		send_byte(8'h61);
		send_byte(T_IAC);
		send_byte(T_IAC);
		shut_sub();
		open_sub();
		send_byte(8'h05);
		send_byte(8'h07);
		shut_sub();
		send_cmd(VERB_WONT, O_ECHO);
		send_cmd(T_DO, O_ECHO);
		send_overflow();
	endtask

	initial begin
		rx_if.valid = 1'b0;
		rx_if.rx_byte = 8'h00;
		cfg_we = 1'b0;
		cfg_wdata = BRK_LOCAL;
		arst_n = 1'b0;
		calm = 1'b0;
		bytes_sent = 0;
		board = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_run();
		await_quiet();
		write_break_mode(BRK_NONE);
		edge_run();
		random_run(20);
		await_quiet();
		write_break_mode(BRK_REMOTE);
		send_byte(T_IAC);
		send_byte(T_BRK);
		random_run(20);
		await_quiet();
		calm = 1'b1;
		write_break_mode(BRK_LOCAL);
		random_run(20);
		await_quiet();

		$display("run covered %0d bytes in, %0d events checked, %0d window reports, %0d tt chars",
			bytes_sent, board.matched, board.windows, board.ttype_chars);
		$display("%0d break commands over all three break modes, %0d overflows, %0d mismatches",
			board.breaks, board.aborts, board.mismatches);
		if (board.mismatches == 0 && board.outstanding() == 0)
			$display("telnet_iac_parser test passed");
		else
			$display("telnet_iac_parser test failed");
		$finish;
	end
endmodule
